FILE: src/dcm_pkg.sv
// Shared types and constants for the DNA context model counter.
`timescale 1ns / 1ps
`default_nettype none

package dcm_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_CONTEXT_ORDER = 2'd0,
        REG_ALPHA_DEN     = 2'd1,
        REG_HALVE_LIMIT   = 2'd2
    } reg_index_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [3:0] RESET_CONTEXT_ORDER = 4'd8;
    localparam logic [7:0] RESET_ALPHA_DEN     = 8'd1;
    localparam logic [7:0] RESET_HALVE_LIMIT   = 8'd255;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [3:0] context_order;
        logic [7:0] alpha_den;
        logic [7:0] halve_limit;
    } cfg_t;

    // Occupancy of the update pipeline.
    typedef struct packed {
        logic clearing;
        logic s1_valid;
        logic s2_valid;
    } rmw_status_t;

    localparam int SYMBOL_W    = 2;
    localparam int FREQ_W      = 16;
    localparam int TOTAL_W     = 18;
    localparam int ITEM_W      = 4 * FREQ_W + TOTAL_W;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 88;

    // Result queue sizing.
    localparam int OUT_DEPTH = 8;
    localparam int OUT_PTR_W = 3;
    localparam int OUT_CNT_W = 4;

endpackage

`default_nettype wire

FILE: src/dna_context_model_counter_top.sv
// Top level of the order-k DNA context model with per-context symbol counters.
//
//  Channel   Direction  Handshake                      Contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  one base symbol per item
//  m_axis    out        m_axis_tvalid / m_axis_tready  four frequencies and total
//  cfg       in         cfg_we (no back-pressure)      register index and data
//
// One item is accepted per cycle in steady state. An item reads its context entry in the
// cycle it is accepted, is updated and written back in the next cycle (a bypass register
// covers back-to-back hits on one entry), and its result enters the output queue through
// the s1, s2 and frequency registers. After reset the table is cleared one entry per
// cycle, all 4^MAX_ORDER entries (65536 at default); items wait, config writes are taken.
// s_axis_tready also drops while queued plus in-flight items fill the eight-entry queue.
`timescale 1ns / 1ps
`default_nettype none

module dna_context_model_counter_top #(
    parameter int MAX_ORDER    = 8,
    parameter int COUNTER_BITS = 8
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // [1:0] symbol
    input  wire logic [dcm_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // [15:0] freq_a, [31:16] freq_c, [47:32] freq_g, [63:48] freq_t, [81:64] freq_total
    output logic      [dcm_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [dcm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [dcm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    dcm_pkg::cfg_t        cfg_reg, cfg_next;
    dcm_pkg::rmw_status_t status;

    logic                            in_accept;
    logic                            out_pop;
    logic [4*COUNTER_BITS-1:0]       cnt_data;
    logic                            res_valid;
    logic [dcm_pkg::ITEM_W-1:0]      res_item;
    logic [dcm_pkg::ITEM_W-1:0]      out_item;
    logic [dcm_pkg::OUT_CNT_W-1:0]   fifo_count;
    logic [dcm_pkg::OUT_CNT_W-1:0]   occupancy;

    // Config registers: the user writes them only while idle; the block does not check.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                dcm_pkg::REG_CONTEXT_ORDER: cfg_next.context_order = cfg_data[3:0];
                dcm_pkg::REG_ALPHA_DEN:     cfg_next.alpha_den     = cfg_data;
                dcm_pkg::REG_HALVE_LIMIT:   cfg_next.halve_limit   = cfg_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.context_order <= dcm_pkg::RESET_CONTEXT_ORDER;
            cfg_reg.alpha_den     <= dcm_pkg::RESET_ALPHA_DEN;
            cfg_reg.halve_limit   <= dcm_pkg::RESET_HALVE_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Every accepted item has a reserved queue slot: count the items already
    // queued plus those still in the three pipeline stages.
    assign occupancy = fifo_count
                     + dcm_pkg::OUT_CNT_W'(status.s1_valid)
                     + dcm_pkg::OUT_CNT_W'(status.s2_valid)
                     + dcm_pkg::OUT_CNT_W'(res_valid);

    assign s_axis_tready = !status.clearing && (occupancy < dcm_pkg::OUT_CNT_W'(dcm_pkg::OUT_DEPTH));
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_pop       = m_axis_tvalid && m_axis_tready;

    dcm_rmw #(
        .MAX_ORDER    (MAX_ORDER),
        .COUNTER_BITS (COUNTER_BITS)
    ) u_rmw (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_accept (in_accept),
        .in_symbol (s_axis_tdata[dcm_pkg::SYMBOL_W-1:0]),
        .status    (status),
        .cnt_data  (cnt_data)
    );

    dcm_freq #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_freq (
        .clk       (clk),
        .rst_n     (rst_n),
        .alpha_den (cfg_reg.alpha_den),
        .cnt_valid (status.s2_valid),
        .cnt_data  (cnt_data),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    dcm_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_item (res_item),
        .pop       (out_pop),
        .out_valid (m_axis_tvalid),
        .out_item  (out_item),
        .count     (fifo_count)
    );

    assign m_axis_tdata = {(dcm_pkg::OUT_TDATA_W - dcm_pkg::ITEM_W)'(0), out_item};

    // The credit scheme must never let the queue overfill.
    assert property (@(posedge clk) disable iff (!rst_n)
        occupancy <= dcm_pkg::OUT_CNT_W'(dcm_pkg::OUT_DEPTH))
        else $error("result queue occupancy exceeds its depth");

    // An accepted item always reaches the queue, through the s1, s2 and frequency registers.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |-> ##3 res_valid)
        else $error("accepted item did not reach the result queue");

    // Nothing can come out while the table is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        status.clearing |-> !m_axis_tvalid && !status.s1_valid)
        else $error("activity during the clearing pass");

endmodule

`default_nettype wire

FILE: src/dcm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dcm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/dcm_rmw.sv
// Context register, counter table clearing pass and read-modify-write update.
`timescale 1ns / 1ps
`default_nettype none

module dcm_rmw #(
    parameter int MAX_ORDER    = 8,
    parameter int COUNTER_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire dcm_pkg::cfg_t                 cfg,
    input  wire logic                          in_accept,
    input  wire logic [dcm_pkg::SYMBOL_W-1:0]  in_symbol,
    output dcm_pkg::rmw_status_t               status,
    output logic      [4*COUNTER_BITS-1:0]     cnt_data
);

    localparam int AW    = 2 * MAX_ORDER;
    localparam int DEPTH = 1 << AW;
    localparam int LANE  = COUNTER_BITS;
    localparam int DW    = 4 * LANE;
    localparam int CMPW  = (COUNTER_BITS > 8) ? COUNTER_BITS : 8;

    logic          clr_active_reg, clr_active_next;
    logic [AW-1:0] clr_addr_reg, clr_addr_next;
    logic [AW-1:0] ctx_reg, ctx_next;

    logic                         s1_valid_reg, s1_valid_next;
    logic [AW-1:0]                s1_addr_reg, s1_addr_next;
    logic [dcm_pkg::SYMBOL_W-1:0] s1_sym_reg, s1_sym_next;

    logic          lw_valid_reg, lw_valid_next;
    logic [AW-1:0] lw_addr_reg, lw_addr_next;
    logic [DW-1:0] lw_data_reg, lw_data_next;

    logic          s2_valid_reg, s2_valid_next;
    logic [DW-1:0] s2_cnt_reg, s2_cnt_next;

    logic [3:0]      eff_order;
    logic [AW-1:0]   ctx_mask;
    logic [AW-1:0]   rd_addr;
    logic [DW-1:0]   ram_rdata;
    logic [DW-1:0]   cur_data;
    logic [LANE-1:0] old_cnt [4];
    logic [LANE-1:0] new_cnt [4];
    logic [LANE-1:0] bumped;
    logic            halve;
    logic [DW-1:0]   new_data;
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata;

    // Order zero acts as one; orders above the table size saturate.
    always_comb
    begin
        eff_order = cfg.context_order;
        if (eff_order == 4'd0)
        begin
            eff_order = 4'd1;
        end
        else if (eff_order > 4'(MAX_ORDER))
        begin
            eff_order = 4'(MAX_ORDER);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ORDER; i++)
        begin
            ctx_mask[2*i +: 2] = (4'(i) < eff_order) ? 2'b11 : 2'b00;
        end
    end

    assign rd_addr = ctx_reg & ctx_mask;

    always_comb
    begin
        ctx_next      = ctx_reg;
        s1_valid_next = in_accept;
        s1_addr_next  = rd_addr;
        s1_sym_next   = in_symbol;
        if (in_accept)
        begin
            ctx_next = ((ctx_reg << 2) | AW'(in_symbol)) & ctx_mask;
        end
    end

    // The entry written last cycle is not yet visible in the read data.
    assign cur_data = (lw_valid_reg && (lw_addr_reg == s1_addr_reg)) ? lw_data_reg : ram_rdata;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            old_cnt[j] = cur_data[j*LANE +: LANE];
        end
        bumped = old_cnt[s1_sym_reg] + LANE'(1);
        halve  = (CMPW'(bumped) == CMPW'(cfg.halve_limit));
        for (int j = 0; j < 4; j++)
        begin
            new_cnt[j] = (s1_sym_reg == 2'(j)) ? bumped : old_cnt[j];
            if (halve)
            begin
                new_cnt[j] = new_cnt[j] >> 1;
            end
            new_data[j*LANE +: LANE] = new_cnt[j];
        end
    end

    // Clearing pass walks every entry once after reset.
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + AW'(1);
            if (clr_addr_reg == {AW{1'b1}})
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    assign ram_we    = clr_active_reg || s1_valid_reg;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_active_reg ? '0 : new_data;

    assign lw_valid_next = s1_valid_reg;
    assign lw_addr_next  = s1_addr_reg;
    assign lw_data_next  = new_data;
    assign s2_valid_next = s1_valid_reg;
    assign s2_cnt_next   = s1_valid_reg ? cur_data : s2_cnt_reg;

    dcm_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            ctx_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            lw_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            ctx_reg        <= ctx_next;
            s1_valid_reg   <= s1_valid_next;
            lw_valid_reg   <= lw_valid_next;
            s2_valid_reg   <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_addr_reg <= s1_addr_next;
        s1_sym_reg  <= s1_sym_next;
        lw_addr_reg <= lw_addr_next;
        lw_data_reg <= lw_data_next;
        s2_cnt_reg  <= s2_cnt_next;
    end

    assign status.clearing = clr_active_reg;
    assign status.s1_valid = s1_valid_reg;
    assign status.s2_valid = s2_valid_reg;
    assign cnt_data        = s2_cnt_reg;

endmodule

`default_nettype wire

FILE: src/dcm_freq.sv
// Frequency estimation: one multiplier per base, then the total.
`timescale 1ns / 1ps
`default_nettype none

module dcm_freq #(
    parameter int COUNTER_BITS = 8
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [7:0]                    alpha_den,
    input  wire logic                          cnt_valid,
    input  wire logic [4*COUNTER_BITS-1:0]     cnt_data,
    output logic                               res_valid,
    output logic      [dcm_pkg::ITEM_W-1:0]    res_item
);

    localparam int LANE = COUNTER_BITS;
    localparam int FW   = (COUNTER_BITS + 8 > dcm_pkg::FREQ_W) ? COUNTER_BITS + 8
                                                               : dcm_pkg::FREQ_W;
    localparam int SW   = FW + 2;

    logic          f_valid_reg, f_valid_next;
    logic [FW-1:0] f_reg  [4];
    logic [FW-1:0] f_next [4];
    logic [SW-1:0] total;

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            f_next[j] = FW'(1) + FW'(alpha_den) * FW'(cnt_data[j*LANE +: LANE]);
        end
    end

    assign f_valid_next = cnt_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_valid)
        begin
            for (int j = 0; j < 4; j++)
            begin
                f_reg[j] <= f_next[j];
            end
        end
    end

    // The total uses the unmasked frequencies.
    assign total = SW'(f_reg[0]) + SW'(f_reg[1]) + SW'(f_reg[2]) + SW'(f_reg[3]);

    assign res_valid = f_valid_reg;
    assign res_item  = {total[dcm_pkg::TOTAL_W-1:0],
                        f_reg[3][dcm_pkg::FREQ_W-1:0],
                        f_reg[2][dcm_pkg::FREQ_W-1:0],
                        f_reg[1][dcm_pkg::FREQ_W-1:0],
                        f_reg[0][dcm_pkg::FREQ_W-1:0]};

endmodule

`default_nettype wire

FILE: src/dcm_fifo.sv
// Result queue that decouples the fixed-latency pipeline from the output side.
`timescale 1ns / 1ps
`default_nettype none

module dcm_fifo (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire logic [dcm_pkg::ITEM_W-1:0]     push_item,
    input  wire logic                           pop,
    output logic                                out_valid,
    output logic      [dcm_pkg::ITEM_W-1:0]     out_item,
    output logic      [dcm_pkg::OUT_CNT_W-1:0]  count
);

    logic [dcm_pkg::ITEM_W-1:0]    mem_reg [dcm_pkg::OUT_DEPTH];
    logic [dcm_pkg::OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dcm_pkg::OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dcm_pkg::OUT_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + dcm_pkg::OUT_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + dcm_pkg::OUT_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + dcm_pkg::OUT_CNT_W'(push) - dcm_pkg::OUT_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking testbench for the DNA context model counter with its own count table.
`timescale 1ns / 1ps

module testbench;

    import dcm_pkg::*;

    localparam int ORDER_MAX      = 8;
    localparam int COUNT_W        = 8;
    localparam int CTX_W          = 2 * ORDER_MAX;
    localparam int WATCHDOG_LIMIT = 200000;
    localparam int PHASES         = 8;
    localparam int PRESSURE_PHASE = 2;
    localparam int DIRECTED_ROWS  = 31;

    // One result item, freq_a in the lowest bits as on m_axis_tdata.
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [FREQ_W-1:0]  freq_t;
        logic [FREQ_W-1:0]  freq_g;
        logic [FREQ_W-1:0]  freq_c;
        logic [FREQ_W-1:0]  freq_a;
    } freq_item_t;

    // A directed row is either a register write or one base with an optional typed result.
    typedef struct {
        bit         is_cfg;
        reg_index_t sel;
        logic [7:0] value;
        logic [1:0] base;
        bit         typed;
        freq_item_t want;
    } stim_row_t;

    typedef enum {STYLE_UNIFORM, STYLE_BIASED, STYLE_MOTIF} style_t;

    typedef struct {
        logic [7:0] order_val;
        logic [7:0] alpha;
        logic [7:0] limit;
        int         items;
        style_t     style;
        bit         idle;
    } phase_t;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    // Predictor state: register copies, the context and the per-context base counts.
    logic [3:0]         order_reg;
    logic [7:0]         alpha_reg;
    logic [7:0]         limit_reg;
    logic [CTX_W-1:0]   context_bits;
    bit [COUNT_W-1:0]   base_counts [1 << CTX_W][4];

    freq_item_t pending_freqs [$];
    int         error_count;
    int         idle_cycles;
    int         rx_hold_cycles;
    bit         tx_idle;
    bit         rx_idle;

    stim_row_t  directed_rows [DIRECTED_ROWS];
    phase_t     plan [PHASES];

    dna_context_model_counter_top #(
        .MAX_ORDER    (ORDER_MAX),
        .COUNTER_BITS (COUNT_W)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic stim_row_t sym_row(input logic [1:0] base);
        stim_row_t row;
        row = '{1'b0, REG_CONTEXT_ORDER, 8'd0, base, 1'b0, '0};
        return row;
    endfunction

    function automatic stim_row_t typed_row(input logic [1:0] base, input int a, input int c,
                                            input int g, input int t, input int tot);
        stim_row_t row;
        row = sym_row(base);
        row.typed = 1'b1;
        row.want = '{TOTAL_W'(tot), FREQ_W'(t), FREQ_W'(g), FREQ_W'(c), FREQ_W'(a)};
        return row;
    endfunction

    function automatic stim_row_t cfg_row(input reg_index_t sel, input logic [7:0] value);
        stim_row_t row;
        row = '{1'b1, sel, value, 2'd0, 1'b0, '0};
        return row;
    endfunction

    // Reads the estimate for the current context, then counts the base, halves the
    // context on reaching the limit, and shifts the base into the context.
    task automatic count_symbol(input logic [1:0] base, output freq_item_t est);
        int               k;
        int               j;
        int               sum;
        int               f [4];
        logic [CTX_W-1:0] mask;
        logic [CTX_W-1:0] ctx;
        logic [COUNT_W-1:0] bumped;
        k = int'(order_reg);
        if (k < 1)
            k = 1;
        if (k > ORDER_MAX)
            k = ORDER_MAX;
        mask = CTX_W'((64'd1 << (2 * k)) - 64'd1);
        ctx = context_bits & mask;
        sum = 0;
        for (j = 0; j < 4; j++)
        begin
            f[j] = 1 + int'(alpha_reg) * int'(base_counts[ctx][j]);
            sum += f[j];
        end
        est.freq_a = FREQ_W'(f[0]);
        est.freq_c = FREQ_W'(f[1]);
        est.freq_g = FREQ_W'(f[2]);
        est.freq_t = FREQ_W'(f[3]);
        est.total  = TOTAL_W'(sum);
        bumped = base_counts[ctx][base] + 1'b1;
        base_counts[ctx][base] = bumped;
        // A counter that wraps to zero counts as reaching a limit of zero.
        if (COUNT_W'(limit_reg) == bumped && (COUNT_W >= 8 || limit_reg < (1 << COUNT_W)))
        begin
            for (j = 0; j < 4; j++)
                base_counts[ctx][j] = base_counts[ctx][j] >> 1;
        end
        context_bits = {context_bits[CTX_W-3:0], base} & mask;
    endtask

    task automatic check_field(input string name, input int unsigned want_v,
                               input int unsigned got_v);
        if (want_v != got_v)
        begin
            error_count++;
            $display("%0t ns: %s expected %0d, actual %0d", $time, name, want_v, got_v);
        end
    endtask

    // Offers one base after a random gap if tx_idle, then predicts its result once taken.
    task automatic send_symbol(input logic [1:0] base, input bit typed, input freq_item_t want);
        int         gap;
        freq_item_t est;
        gap = tx_idle ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_TDATA_W'(base);
        do
            @(posedge clk);
        while (!s_axis_tready);
        count_symbol(base, est);
        pending_freqs.push_back(typed ? want : est);
    endtask

    // Stops offering items until every predicted result has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_freqs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input reg_index_t sel, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (sel)
            REG_CONTEXT_ORDER: order_reg = value[3:0];
            REG_ALPHA_DEN:     alpha_reg = value;
            REG_HALVE_LIMIT:   limit_reg = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Result side: random stalls per item while rx_idle, plus one long hold-off on request.
    initial
    begin : result_sink
        int stall;
        int hold;
        m_axis_tready = 1'b0;
        @(posedge clk);
        forever
        begin
            if (rx_hold_cycles != 0)
            begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            stall = rx_idle ? $urandom_range(0, 5) : 0;
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
        end
    end

    // Every result item is compared field by field with the oldest prediction.
    always @(posedge clk)
    begin
        freq_item_t got;
        freq_item_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = freq_item_t'(m_axis_tdata[ITEM_W-1:0]);
            if (pending_freqs.size() == 0)
            begin
                error_count++;
                $display("%0t ns: result item with none expected, expected nothing, actual %h",
                         $time, got);
            end
            else
            begin
                want = pending_freqs.pop_front();
                check_field("freq_a", want.freq_a, got.freq_a);
                check_field("freq_c", want.freq_c, got.freq_c);
                check_field("freq_g", want.freq_g, got.freq_g);
                check_field("freq_t", want.freq_t, got.freq_t);
                check_field("freq_total", want.total, got.total);
            end
        end
    end

    // The limit covers the table clearing pass after reset with room to spare.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t ns: no item moved for %0d cycles", $time, idle_cycles);
            $display("dna_context_model_counter_top verification failed");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        int         p;
        int         n;
        int         r;
        logic [1:0] base;
        logic [1:0] dominant;
        logic [1:0] motif [4];

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = REG_CONTEXT_ORDER;
        cfg_data      = '0;
        order_reg     = RESET_CONTEXT_ORDER;
        alpha_reg     = RESET_ALPHA_DEN;
        limit_reg     = RESET_HALVE_LIMIT;
        context_bits  = '0;
        error_count   = 0;
        idle_cycles   = 0;
        rx_hold_cycles = 0;
        tx_idle       = 1'b1;
        rx_idle       = 1'b1;

        // Reset settings first: fresh contexts read as all ones, repeats count up.
        // Then a limit of one, order zero with limit zero, an order above the
        // maximum, and an order change that keeps the old context bits.
        directed_rows = '{
            typed_row(2'd0, 1, 1, 1, 1, 4),
            typed_row(2'd0, 2, 1, 1, 1, 5),
            typed_row(2'd0, 3, 1, 1, 1, 6),
            typed_row(2'd3, 4, 1, 1, 1, 7),
            typed_row(2'd1, 1, 1, 1, 1, 4),
            typed_row(2'd2, 1, 1, 1, 1, 4),
            cfg_row(REG_ALPHA_DEN, 8'd255),
            cfg_row(REG_HALVE_LIMIT, 8'd1),
            sym_row(2'd0),
            sym_row(2'd0),
            sym_row(2'd0),
            cfg_row(REG_CONTEXT_ORDER, 8'd0),
            cfg_row(REG_HALVE_LIMIT, 8'd0),
            sym_row(2'd1),
            sym_row(2'd1),
            sym_row(2'd1),
            sym_row(2'd1),
            sym_row(2'd1),
            cfg_row(REG_CONTEXT_ORDER, 8'd15),
            cfg_row(REG_HALVE_LIMIT, 8'd2),
            sym_row(2'd2),
            sym_row(2'd2),
            sym_row(2'd3),
            sym_row(2'd2),
            cfg_row(REG_CONTEXT_ORDER, 8'd1),
            cfg_row(REG_ALPHA_DEN, 8'd128),
            cfg_row(REG_HALVE_LIMIT, 8'd255),
            sym_row(2'd3),
            sym_row(2'd0),
            sym_row(2'd3),
            sym_row(2'd3)
        };

        // The biased phase at order one with a zero limit drives one counter past
        // its wrap, so alpha 255 times a full count shows up on the output.
        plan = '{
            '{8'd2,  8'd3,   8'd2,   150, STYLE_UNIFORM, 1'b1},
            '{8'd1,  8'd255, 8'd0,   400, STYLE_BIASED,  1'b0},
            '{8'd15, 8'd128, 8'd255, 200, STYLE_MOTIF,   1'b1},
            '{8'd0,  8'd1,   8'd1,   150, STYLE_UNIFORM, 1'b1},
            '{8'd4,  8'd17,  8'd7,   220, STYLE_MOTIF,   1'b0},
            '{8'd3,  8'd0,   8'd0,   230, STYLE_UNIFORM, 1'b1},
            '{8'd8,  8'd200, 8'd128, 300, STYLE_MOTIF,   1'b1},
            '{8'd6,  8'd85,  8'd64,  200, STYLE_BIASED,  1'b0}
        };
        plan[5].alpha = 8'($urandom_range(1, 255));
        plan[5].limit = 8'($urandom_range(2, 255));
        plan[6].order_val = {4'($urandom_range(0, 15)), 4'd8};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (directed_rows[r].is_cfg)
            begin
                drain_results();
                write_reg(directed_rows[r].sel, directed_rows[r].value);
            end
            else
                send_symbol(directed_rows[r].base, directed_rows[r].typed, directed_rows[r].want);
        end

        for (p = 0; p < PHASES; p++)
        begin
            drain_results();
            write_reg(REG_CONTEXT_ORDER, plan[p].order_val);
            write_reg(REG_ALPHA_DEN, plan[p].alpha);
            write_reg(REG_HALVE_LIMIT, plan[p].limit);
            tx_idle = plan[p].idle;
            rx_idle = plan[p].idle;
            dominant = 2'($urandom_range(0, 3));
            for (n = 0; n < 4; n++)
                motif[n] = 2'($urandom_range(0, 3));
            for (n = 0; n < plan[p].items; n++)
            begin
                case (plan[p].style)
                    STYLE_BIASED:
                        base = ($urandom_range(0, 99) < 95) ? dominant
                                                            : 2'($urandom_range(0, 3));
                    STYLE_MOTIF:
                        base = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 3))
                                                           : motif[n % 4];
                    default:
                        base = 2'($urandom_range(0, 3));
                endcase
                // Hold the result side off long enough for the input to stall,
                // and later let everything drain with no register change.
                if (p == PRESSURE_PHASE && n == 50)
                    rx_hold_cycles = 80;
                if (p == PRESSURE_PHASE && n == 120)
                    drain_results();
                send_symbol(base, 1'b0, '0);
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_freqs.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("dna_context_model_counter_top verification clean");
        else
            $display("dna_context_model_counter_top verification failed");
        $finish;
    end

endmodule
